[hdl/lkv_pkg.sv]
// ============================================================================
// lkv_pkg
// Shared widths, codes and the controller-to-datapath command word for the
// LRU key/value cache.
// ============================================================================
package lkv_pkg;

    // Store geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SCAN_W  = $clog2(ENTRIES + 1);

    // Word fields
    localparam int KEY_W = 32;
    localparam int VAL_W = 64;

    // Configuration
    localparam int CAP_W      = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Register index (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    // Request action codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             capture;   // latch request, clear scan results
        logic             cmp_en;    // compare entry cmp_idx against request
        logic [IDX_W-1:0] cmp_idx;
        logic [IDX_W-1:0] rd_addr;   // key/value RAM read address
        logic             commit;    // apply the state update
        logic             load_out;  // load the result register
    } lkv_cmd_t;

endpackage

[hdl/lkv_ram.sv]
// ============================================================================
// lkv_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ============================================================================
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/lkv_ctrl.sv]
// ============================================================================
// lkv_ctrl
// Request sequencer: accepts a word, steps the key scan through every
// entry, commits the update and hands the result to the output register.
// ============================================================================
module lkv_ctrl import lkv_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output lkv_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SCAN_W-1:0] cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [SCAN_W-1:0] cnt_prev;

    assign cnt_prev = cnt_reg - SCAN_W'(1);

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        cmd           = '0;
        cmd.rd_addr   = cnt_reg[IDX_W-1:0];
        cmd.cmp_idx   = cnt_prev[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                // read issued at cnt, compared in the next cycle
                cmd.cmp_en = (cnt_reg != '0);
                cnt_next   = cnt_reg + SCAN_W'(1);
                if (cnt_reg == SCAN_W'(ENTRIES)) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[hdl/lkv_datapath.sv]
// ============================================================================
// lkv_datapath
// Key and value RAMs, valid bits, recency ranks, occupancy, the capacity
// register, scan result registers and the result word register.
// ============================================================================
module lkv_datapath import lkv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  lkv_cmd_t         cmd,
    input  logic             s_action,
    input  logic [KEY_W-1:0] s_key,
    input  logic [VAL_W-1:0] s_value,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    output logic [CAP_W-1:0] capacity,
    output logic             m_hit,
    output logic [VAL_W-1:0] m_read_value
);

    // Request
    logic             act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    // Scan results
    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg, found_idx_next;
    logic [VAL_W-1:0] hit_val_reg, hit_val_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             vic_reg, vic_next;
    logic [IDX_W-1:0] vic_idx_reg, vic_idx_next;
    logic [RANK_W-1:0] vic_rank_reg, vic_rank_next;

    // Entry state
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]  rank_reg [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CAP_W-1:0]   cap_reg;

    // Result word
    logic             m_hit_reg;
    logic [VAL_W-1:0] m_read_value_reg;

    // RAM ports
    logic [KEY_W-1:0] key_rd;
    logic [VAL_W-1:0] val_rd;
    logic             key_we, val_we;
    logic [IDX_W-1:0] key_waddr, val_waddr;
    logic [VAL_W-1:0] val_wdata;

    // Commit decode
    logic [CNT_W-1:0]  eff_cap;
    logic              is_put;
    logic              do_evict;
    logic              do_insert;
    logic [IDX_W-1:0]  slot;
    logic [RANK_W-1:0] found_rank;
    logic              cmp_valid;
    logic [RANK_W-1:0] cmp_rank;

    lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (cmd.rd_addr),
        .rdata (key_rd)
    );

    lkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (cmd.rd_addr),
        .rdata (val_rd)
    );

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    assign capacity = cap_reg;

    // Zero behaves as one, anything above the store size saturates
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (CNT_W'(cap_reg) > CNT_W'(ENTRIES)) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg <= s_action;
            key_reg <= s_key;
            val_reg <= s_value;
        end
    end

    // Scan step: first match, first free slot, oldest entry (last on a tie)
    assign cmp_valid = valid_reg[cmd.cmp_idx];
    assign cmp_rank  = rank_reg[cmd.cmp_idx];

    always_comb begin
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        hit_val_next   = hit_val_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        vic_next       = vic_reg;
        vic_idx_next   = vic_idx_reg;
        vic_rank_next  = vic_rank_reg;
        if (cmd.capture) begin
            found_next = 1'b0;
            free_next  = 1'b0;
            vic_next   = 1'b0;
        end else if (cmd.cmp_en) begin
            if (cmp_valid && key_rd == key_reg && !found_reg) begin
                found_next     = 1'b1;
                found_idx_next = cmd.cmp_idx;
                hit_val_next   = val_rd;
            end
            if (!cmp_valid && !free_reg) begin
                free_next     = 1'b1;
                free_idx_next = cmd.cmp_idx;
            end
            if (cmp_valid && (!vic_reg || cmp_rank >= vic_rank_reg)) begin
                vic_next      = 1'b1;
                vic_idx_next  = cmd.cmp_idx;
                vic_rank_next = cmp_rank;
            end
        end
    end

    always_ff @(posedge aclk) begin
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        hit_val_reg   <= hit_val_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        vic_reg       <= vic_next;
        vic_idx_reg   <= vic_idx_next;
        vic_rank_reg  <= vic_rank_next;
    end

    // Commit decode
    assign is_put     = (act_reg == ACT_PUT);
    assign found_rank = rank_reg[found_idx_reg];
    assign do_evict   = is_put && !found_reg && (occ_reg >= eff_cap) && vic_reg;
    assign do_insert  = is_put && !found_reg && (do_evict || free_reg);

    // After an eviction the lowest free slot may be the victim's
    always_comb begin
        if (do_evict && !(free_reg && free_idx_reg < vic_idx_reg)) begin
            slot = vic_idx_reg;
        end else begin
            slot = free_idx_reg;
        end
    end

    // RAM writes
    assign key_we    = cmd.commit && do_insert;
    assign key_waddr = slot;
    assign val_we    = cmd.commit && (do_insert || (is_put && found_reg));
    assign val_waddr = found_reg ? found_idx_reg : slot;
    assign val_wdata = val_reg;

    // Valid bits, ranks and occupancy
    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.commit) begin
            if (found_reg) begin
                // promote: younger entries age by one
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && rank_reg[i] < found_rank) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                    if (IDX_W'(i) == found_idx_reg) begin
                        rank_next[i] = '0;
                    end
                end
            end else if (do_insert) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (do_evict && IDX_W'(i) == vic_idx_reg) begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end else if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                    if (IDX_W'(i) == slot) begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                end
                if (!do_evict) begin
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Result word: value only on a get hit
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_hit_reg        <= found_reg;
            m_read_value_reg <= (found_reg && !is_put) ? hit_val_reg : '0;
        end
    end

    assign m_hit        = m_hit_reg;
    assign m_read_value = m_read_value_reg;

endmodule

[hdl/lru_key_value_cache.sv]
// A word accepted in idle passes through the scan, update and result states;
// the scan reads one key per cycle through the key RAM's single read port.
// One word is worked on at a time; a waiting result does not block acceptance.
// Reset (aresetn, synchronous, active low) clears valid bits, ranks, occupancy
// and handshakes, and sets capacity to 16; RAM contents are left as they are.
// ============================================================================
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement,
// APB capacity register and valid/ready request and result channels.
// ============================================================================
module lru_key_value_cache import lkv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [KEY_W-1:0]      s_key,
    input  logic [VAL_W-1:0]      s_value,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [VAL_W-1:0]      m_read_value
);

    lkv_cmd_t         cmd;
    logic             cfg_we;
    logic [CAP_W-1:0] capacity;

    // APB decode
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = {{(APB_DATA_W-CAP_W){1'b0}}, capacity};
        end
    end

    lkv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lkv_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_action     (s_action),
        .s_key        (s_key),
        .s_value      (s_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (pwdata[CAP_W-1:0]),
        .capacity     (capacity),
        .m_hit        (m_hit),
        .m_read_value (m_read_value)
    );

    // Busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while a word is in flight");

    // No compare while idle
    a_scan_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cmp_en |-> !s_ready)
        else $error("scan step while idle");

    // Commit is a single cycle
    a_commit_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> !cmd.commit)
        else $error("state update repeated");

    // Loading the result register presents a word
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("result loaded but not presented");

endmodule

[test/tb_lru_key_value_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key/value cache. A behavioural copy of the
// store (keys, payloads, valid bits, recency ranks) predicts hit and read
// value for every accepted request word. Each result word is compared in
// order. Directed tests cover extreme keys and payloads, hits and misses,
// eviction order and capacity corner values. Random traffic then runs under
// several capacities and idling patterns, with one long result hold-off.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
    import lkv_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_GAP      = 40;

    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } reply_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    logic                  s_action = ACT_GET;
    logic [KEY_W-1:0]      s_key    = '0;
    logic [VAL_W-1:0]      s_value  = '0;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    logic                  m_hit;
    logic [VAL_W-1:0]      m_read_value;

    // Shadow copy of the store
    logic [KEY_W-1:0] mdl_keys   [ENTRIES];
    logic [VAL_W-1:0] mdl_values [ENTRIES];
    bit               mdl_valid  [ENTRIES];
    int               mdl_rank   [ENTRIES];
    int               mdl_count;
    logic [CAP_W-1:0] mdl_capacity;

    reply_t pending_replies[$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_off_left  = 0;

    lru_key_value_cache dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_read_value (m_read_value)
    );

    always #4 aclk = ~aclk;

    // Zero acts as one, anything above the store size saturates
    function automatic int usable_entries();
        int c;
        c = int'(mdl_capacity);
        if (c == 0) c = 1;
        if (c > ENTRIES) c = ENTRIES;
        return c;
    endfunction

    // Slot becomes most recent; younger valid entries age by one
    function automatic void make_most_recent(int slot);
        int r;
        r = mdl_rank[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (mdl_valid[i] && mdl_rank[i] < r) mdl_rank[i]++;
        mdl_rank[slot] = 0;
    endfunction

    // Apply one request to the shadow store and return the reply it gives
    function automatic reply_t lookup_and_update(logic act, logic [KEY_W-1:0] key,
                                                 logic [VAL_W-1:0] value);
        int     found;
        int     victim;
        int     slot;
        reply_t r;
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && mdl_valid[i] && mdl_keys[i] == key) found = i;
        r.hit        = (found >= 0);
        r.read_value = '0;
        if (act == ACT_GET) begin
            if (found >= 0) begin
                r.read_value = mdl_values[found];
                make_most_recent(found);
            end
        end else if (found >= 0) begin
            mdl_values[found] = value;
            make_most_recent(found);
        end else begin
            // full: drop the oldest valid entry first
            if (mdl_count >= usable_entries()) begin
                victim = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (mdl_valid[i] && (victim < 0 || mdl_rank[i] >= mdl_rank[victim]))
                        victim = i;
                if (victim >= 0) begin
                    mdl_valid[victim] = 1'b0;
                    mdl_rank[victim]  = 0;
                    mdl_count--;
                end
            end
            // lowest free slot takes the new pair
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !mdl_valid[i]) slot = i;
            if (slot >= 0) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (mdl_valid[i]) mdl_rank[i]++;
                mdl_keys[slot]   = key;
                mdl_values[slot] = value;
                mdl_valid[slot]  = 1'b1;
                mdl_rank[slot]   = 0;
                mdl_count++;
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // Result word checker
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_replies.size() == 0) begin
                note_mismatch("unexpected result word", '0, m_read_value);
            end else begin
                want = pending_replies.pop_front();
                if (m_hit !== want.hit)
                    note_mismatch("hit", VAL_W'(want.hit), VAL_W'(m_hit));
                if (m_read_value !== want.read_value)
                    note_mismatch("read_value", want.read_value, m_read_value);
            end
        end
    end

    // Result side: long hold-off when asked, else random stalls
    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one request word, hold it until taken, then log its reply
    task automatic send_word(logic act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(MAX_GAP, 1);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_key    <= key;
        s_value  <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_replies.push_back(lookup_and_update(act, key, value));
    endtask

    // Stop offering and wait for every outstanding reply
    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    // Write capacity, then read it back
    task automatic set_capacity(logic [CAP_W-1:0] cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= APB_DATA_W'(cap);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        mdl_capacity = cap;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata[CAP_W-1:0] !== cap)
            note_mismatch("capacity read-back", VAL_W'(cap), VAL_W'(prdata[CAP_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Empty-store miss, extreme keys and payloads, put hit, ignored get payload
    task automatic test_basic_lookups();
        send_word(ACT_GET, '0, {$urandom, $urandom});
        send_word(ACT_PUT, '0, '1);
        send_word(ACT_GET, '0, '0);
        send_word(ACT_PUT, '1, '0);
        send_word(ACT_PUT, '0, 64'h0123_4567_89ab_cdef);
        send_word(ACT_GET, '1, '1);
        send_word(ACT_GET, '0, '0);
        send_word(ACT_GET, 32'h5a5a_a5a5, '1);
        drain_replies();
    endtask

    // Small capacity: a get refreshes an entry so the next oldest is evicted
    task automatic test_eviction_order();
        set_capacity(CAP_W'(3));
        send_word(ACT_PUT, 32'd10, 64'h10);
        send_word(ACT_PUT, 32'd11, 64'h11);
        send_word(ACT_PUT, 32'd12, 64'h12);
        send_word(ACT_GET, 32'd10, '0);
        send_word(ACT_PUT, 32'd13, 64'h13);
        send_word(ACT_GET, 32'd11, '0);
        send_word(ACT_GET, 32'd12, '0);
        drain_replies();
    endtask

    // Zero capacity acts as one (and sits below occupancy); all-ones saturates
    task automatic test_capacity_extremes();
        set_capacity(CAP_W'(0));
        send_word(ACT_PUT, 32'd20, {$urandom, $urandom});
        send_word(ACT_PUT, 32'd21, {$urandom, $urandom});
        send_word(ACT_GET, 32'd20, '0);
        send_word(ACT_GET, 32'd21, '0);
        drain_replies();
        set_capacity('1);
        send_word(ACT_PUT, 32'd30, {$urandom, $urandom});
        send_word(ACT_PUT, 32'd31, {$urandom, $urandom});
        send_word(ACT_GET, 32'd30, '0);
        send_word(ACT_GET, 32'd21, '0);
        drain_replies();
    endtask

    // Results held off for a long stretch while requests keep coming
    task automatic test_backpressure();
        set_capacity(CAP_W'(16));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 300;
        for (int n = 0; n < 12; n++)
            send_word(logic'($urandom_range(1)), KEY_W'(40 + n % 4), {$urandom, $urandom});
        drain_replies();
    endtask

    // Random traffic over a key pool a little larger than the capacity
    task automatic test_random_traffic();
        logic [CAP_W-1:0] settings [8] = '{CAP_W'(16), CAP_W'(1), CAP_W'(5), CAP_W'(0),
                                           CAP_W'(31), CAP_W'(8), CAP_W'(12), CAP_W'(3)};
        logic [KEY_W-1:0] key_pool [24];
        int               pool_n;
        int               pick;
        logic             act;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        settings[6] = CAP_W'($urandom_range(15, 2));
        for (int p = 0; p < 8; p++) begin
            set_capacity(settings[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            pool_n = usable_entries() + 4;
            for (int k = 0; k < 24; k++) key_pool[k] = $urandom;
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int n = 0; n < 235; n++) begin
                pick  = $urandom_range(99);
                act   = logic'($urandom_range(1));
                key   = (pick < 88) ? key_pool[$urandom_range(pool_n - 1)] : KEY_W'($urandom);
                value = {$urandom, $urandom};
                if (pick >= 96) value = pick[0] ? '1 : '0;
                send_word(act, key, value);
            end
            drain_replies();
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            mdl_valid[i] = 1'b0;
            mdl_rank[i]  = 0;
        end
        mdl_count    = 0;
        mdl_capacity = CAP_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_lookups();
        test_eviction_order();
        test_capacity_extremes();
        test_backpressure();
        test_random_traffic();
        // settle past the block's latency for any stray result
        repeat (25) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[lru_key_value_cache.f]
hdl/lkv_pkg.sv
hdl/lkv_ram.sv
hdl/lkv_ctrl.sv
hdl/lkv_datapath.sv
hdl/lru_key_value_cache.sv
test/tb_lru_key_value_cache.sv
